// ----- hw/rtl/amx_pkg.sv -----
// Package for the accumulator machine execute unit: sizes, opcodes, status codes,
// and the command and status structs that join the controller and the datapath.
// No dependencies.
package amx_pkg;

    localparam int MEM_WORDS    = 1024;
    localparam int ACC_LOCATION = 10;
    localparam int ADDR_W       = $clog2(MEM_WORDS);
    localparam int ACC_INDEX    = ACC_LOCATION % MEM_WORDS;

    localparam int WORD_W = 32;
    localparam int PC_W   = 11;
    localparam int OP_W   = 7;
    localparam int OPND_W = 10;
    localparam int ST_W   = 3;

    localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    // Opcodes
    localparam logic [OP_W-1:0] OP_READ    = 7'd10;
    localparam logic [OP_W-1:0] OP_WRITE   = 7'd11;
    localparam logic [OP_W-1:0] OP_NEWLINE = 7'd12;
    localparam logic [OP_W-1:0] OP_LOAD    = 7'd20;
    localparam logic [OP_W-1:0] OP_STORE   = 7'd21;
    localparam logic [OP_W-1:0] OP_ADD     = 7'd30;
    localparam logic [OP_W-1:0] OP_SUB     = 7'd31;
    localparam logic [OP_W-1:0] OP_DIV     = 7'd32;
    localparam logic [OP_W-1:0] OP_MUL     = 7'd33;
    localparam logic [OP_W-1:0] OP_REM     = 7'd34;
    localparam logic [OP_W-1:0] OP_JMP     = 7'd40;
    localparam logic [OP_W-1:0] OP_JNEG    = 7'd41;
    localparam logic [OP_W-1:0] OP_JZERO   = 7'd42;
    localparam logic [OP_W-1:0] OP_STOP    = 7'd43;

    // Run status codes
    localparam logic [ST_W-1:0] ST_RUN     = 3'd0;
    localparam logic [ST_W-1:0] ST_STOP    = 3'd1;
    localparam logic [ST_W-1:0] ST_END     = 3'd2;
    localparam logic [ST_W-1:0] ST_DIVZERO = 3'd3;
    localparam logic [ST_W-1:0] ST_INVALID = 3'd4;

    typedef struct packed {
        logic clr;
        logic latch;
        logic rd;
        logic mul;
        logic div_start;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic is_mul;
        logic is_div;
        logic div_done;
    } t_sts;

endpackage

// ----- hw/rtl/amx_divider.sv -----
// Restoring unsigned divider for the execute unit, one quotient bit per cycle.
// Depends on amx_pkg.
module amx_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [amx_pkg::WORD_W-1:0]  i_num,
    input  logic [amx_pkg::WORD_W-1:0]  i_den,
    output logic [amx_pkg::WORD_W-1:0]  o_quo,
    output logic [amx_pkg::WORD_W-1:0]  o_rem,
    output logic                        o_done
);
    localparam int W   = amx_pkg::WORD_W;
    localparam int CNT_W = $clog2(W + 1);

    logic [W:0]       r_rem;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [W:0]       shifted;
    logic [W:0]       trial;

    // Shift in one dividend bit and try the subtract
    always_comb begin
        shifted = {r_rem[W-1:0], r_quo[W-1]};
        trial   = shifted - {1'b0, r_den};
    end

    // Control: count the steps, pulse done after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!trial[W]) begin
                r_rem <= trial;
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= shifted;
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    assign o_quo  = r_quo;
    assign o_rem  = r_rem[W-1:0];
    assign o_done = r_done;
endmodule

// ----- hw/rtl/amx_datapath.sv -----
// Datapath of the execute unit: data memory, accumulator, program counter,
// status, multiplier, divider and result registers. Depends on amx_pkg, amx_divider.
module amx_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  amx_pkg::t_cmd               i_cmd,
    output amx_pkg::t_sts               o_sts,
    input  logic                        i_cfg_we,
    input  logic [amx_pkg::PC_W-1:0]    i_cfg_data,
    input  logic                        i_mode,
    input  logic [amx_pkg::OP_W-1:0]    i_opcode,
    input  logic [amx_pkg::OPND_W-1:0]  i_operand,
    input  logic signed [amx_pkg::WORD_W-1:0] i_in_value,
    output logic [amx_pkg::PC_W-1:0]    o_next_pc,
    output logic                        o_out_valid,
    output logic signed [amx_pkg::WORD_W-1:0] o_out_value,
    output logic                        o_newline,
    output logic                        o_overflow,
    output logic [amx_pkg::ST_W-1:0]    o_status
);
    localparam int W  = amx_pkg::WORD_W;
    localparam int AW = amx_pkg::ADDR_W;
    localparam logic [AW-1:0] ACC_ADDR = AW'(amx_pkg::ACC_INDEX);

    logic [W-1:0] mem [amx_pkg::MEM_WORDS];

    logic [amx_pkg::PC_W-1:0]   r_len;
    logic [amx_pkg::PC_W-1:0]   r_pc;
    logic [amx_pkg::ST_W-1:0]   r_status;
    logic [W-1:0]               r_acc;
    logic [AW-1:0]              r_clr_addr;
    logic                       r_mode;
    logic [amx_pkg::OP_W-1:0]   r_op;
    logic [amx_pkg::OPND_W-1:0] r_opnd;
    logic [W-1:0]               r_val;
    logic [W-1:0]               r_rdata;
    logic                       r_in_rng;
    logic signed [2*W-1:0]      r_prod;

    logic [amx_pkg::PC_W-1:0]   r_o_pc;
    logic                       r_o_ovalid;
    logic [W-1:0]               r_o_oval;
    logic                       r_o_nl;
    logic                       r_o_ovf;
    logic [amx_pkg::ST_W-1:0]   r_o_st;

    logic [AW-1:0] opnd_addr;
    logic          opnd_rng;
    logic [W-1:0]  m;
    logic          exec_ok;
    logic [W:0]    sum;
    logic [W:0]    diff;
    logic [W-1:0]  num_mag;
    logic [W-1:0]  den_mag;
    logic [W-1:0]  quo;
    logic [W-1:0]  rem;
    logic          div_done;
    logic [W-1:0]  quo_s;
    logic [W-1:0]  rem_s;
    logic          min_by_m1;
    logic          prod_fits;

    logic [amx_pkg::PC_W-1:0] c_pc;
    logic [amx_pkg::ST_W-1:0] c_st;
    logic                     c_we;
    logic [AW-1:0]            c_wa;
    logic [W-1:0]             c_wd;
    logic                     c_ovalid;
    logic [W-1:0]             c_oval;
    logic                     c_nl;
    logic                     c_ovf;
    logic                     mem_we;
    logic [AW-1:0]            mem_wa;
    logic [W-1:0]             mem_wd;

    // Operand decode and operand word
    always_comb begin
        opnd_addr = AW'(r_opnd);
        opnd_rng  = 32'(r_opnd) < amx_pkg::MEM_WORDS;
        m         = r_in_rng ? r_rdata : '0;
        exec_ok   = r_mode && (r_status == amx_pkg::ST_RUN) && (r_pc < r_len);
        sum       = {r_acc[W-1], r_acc} + {m[W-1], m};
        diff      = {r_acc[W-1], r_acc} - {m[W-1], m};
        num_mag   = r_acc[W-1] ? (~r_acc + 1'b1) : r_acc;
        den_mag   = m[W-1] ? (~m + 1'b1) : m;
        quo_s     = (r_acc[W-1] ^ m[W-1]) ? (~quo + 1'b1) : quo;
        rem_s     = r_acc[W-1] ? (~rem + 1'b1) : rem;
        min_by_m1 = (r_acc == amx_pkg::WORD_MIN) && (m == '1);
        prod_fits = (r_prod[2*W-1:W-1] == '0) || (r_prod[2*W-1:W-1] == '1);
    end

    amx_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (num_mag),
        .i_den   (den_mag),
        .o_quo   (quo),
        .o_rem   (rem),
        .o_done  (div_done)
    );

    // Status back to the controller
    always_comb begin
        o_sts.clr_done = (r_clr_addr == AW'(amx_pkg::MEM_WORDS - 1));
        o_sts.is_mul   = exec_ok && (r_op == amx_pkg::OP_MUL);
        o_sts.is_div   = exec_ok && (m != '0) &&
                         ((r_op == amx_pkg::OP_DIV) || (r_op == amx_pkg::OP_REM));
        o_sts.div_done = div_done;
    end

    // Work out the effect of the held item
    always_comb begin
        c_pc     = r_pc;
        c_st     = r_status;
        c_we     = 1'b0;
        c_wa     = opnd_addr;
        c_wd     = r_val;
        c_ovalid = 1'b0;
        c_oval   = '0;
        c_nl     = 1'b0;
        c_ovf    = 1'b0;
        if (!r_mode) begin
            c_we = opnd_rng;
        end else if (r_status == amx_pkg::ST_RUN) begin
            if (r_pc >= r_len) begin
                c_st = amx_pkg::ST_END;
            end else begin
                c_pc = r_pc + 1'b1;
                case (r_op)
                    amx_pkg::OP_READ: begin
                        c_we = opnd_rng;
                    end
                    amx_pkg::OP_WRITE: begin
                        c_ovalid = 1'b1;
                        c_oval   = m;
                    end
                    amx_pkg::OP_NEWLINE: begin
                        c_nl = 1'b1;
                    end
                    amx_pkg::OP_LOAD: begin
                        c_we = 1'b1;
                        c_wa = ACC_ADDR;
                        c_wd = m;
                    end
                    amx_pkg::OP_STORE: begin
                        c_we = opnd_rng;
                        c_wd = r_acc;
                    end
                    amx_pkg::OP_ADD: begin
                        c_we = 1'b1;
                        c_wa = ACC_ADDR;
                        c_wd = sum[W-1:0];
                        if (sum[W] != sum[W-1]) begin
                            c_ovf = 1'b1;
                            c_wd  = sum[W] ? amx_pkg::WORD_MIN : amx_pkg::WORD_MAX;
                        end
                    end
                    amx_pkg::OP_SUB: begin
                        c_we = 1'b1;
                        c_wa = ACC_ADDR;
                        c_wd = diff[W-1:0];
                        if (diff[W] != diff[W-1]) begin
                            c_ovf = 1'b1;
                            c_wd  = diff[W] ? amx_pkg::WORD_MIN : amx_pkg::WORD_MAX;
                        end
                    end
                    amx_pkg::OP_MUL: begin
                        c_we = 1'b1;
                        c_wa = ACC_ADDR;
                        c_wd = r_prod[W-1:0];
                        if (!prod_fits) begin
                            c_ovf = 1'b1;
                            c_wd  = r_prod[2*W-1] ? amx_pkg::WORD_MIN : amx_pkg::WORD_MAX;
                        end
                    end
                    amx_pkg::OP_DIV: begin
                        if (m == '0) begin
                            c_st = amx_pkg::ST_DIVZERO;
                        end else begin
                            c_we = 1'b1;
                            c_wa = ACC_ADDR;
                            c_wd = quo_s;
                            if (min_by_m1) begin
                                c_ovf = 1'b1;
                                c_wd  = amx_pkg::WORD_MAX;
                            end
                        end
                    end
                    amx_pkg::OP_REM: begin
                        if (m == '0) begin
                            c_st = amx_pkg::ST_DIVZERO;
                        end else begin
                            c_we = 1'b1;
                            c_wa = ACC_ADDR;
                            c_wd = rem_s;
                        end
                    end
                    amx_pkg::OP_JMP: begin
                        c_pc = amx_pkg::PC_W'(r_opnd);
                    end
                    amx_pkg::OP_JNEG: begin
                        if (r_acc[W-1]) c_pc = amx_pkg::PC_W'(r_opnd);
                    end
                    amx_pkg::OP_JZERO: begin
                        if (r_acc == '0) c_pc = amx_pkg::PC_W'(r_opnd);
                    end
                    amx_pkg::OP_STOP: begin
                        c_st = amx_pkg::ST_STOP;
                    end
                    default: begin
                        c_st = amx_pkg::ST_INVALID;
                    end
                endcase
                if ((c_st == amx_pkg::ST_RUN) && (c_pc >= r_len)) c_st = amx_pkg::ST_END;
            end
        end
    end

    // Memory write port: clearing sweep or commit
    always_comb begin
        mem_we = i_cmd.clr || (i_cmd.commit && c_we);
        mem_wa = i_cmd.clr ? r_clr_addr : c_wa;
        mem_wd = i_cmd.clr ? '0 : c_wd;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        if (i_cmd.rd) r_rdata <= mem[opnd_addr];
    end

    // Control state: length, counter, status, accumulator, clear address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_pc       <= '0;
            r_status   <= amx_pkg::ST_RUN;
            r_acc      <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_we) r_len <= i_cfg_data;
            if (i_cmd.clr) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_cmd.commit) begin
                r_pc     <= c_pc;
                r_status <= c_st;
                if (c_we && (c_wa == ACC_ADDR)) r_acc <= c_wd;
            end
        end
    end

    // Hold the accepted item, the range flag and the product
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode <= i_mode;
            r_op   <= i_opcode;
            r_opnd <= i_operand;
            r_val  <= i_in_value;
        end
        if (i_cmd.rd) r_in_rng <= opnd_rng;
        if (i_cmd.mul) r_prod <= $signed(r_acc) * $signed(m);
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_pc     <= c_pc;
            r_o_ovalid <= c_ovalid;
            r_o_oval   <= c_oval;
            r_o_nl     <= c_nl;
            r_o_ovf    <= c_ovf;
            r_o_st     <= c_st;
        end
    end

    assign o_next_pc   = r_o_pc;
    assign o_out_valid = r_o_ovalid;
    assign o_out_value = r_o_oval;
    assign o_newline   = r_o_nl;
    assign o_overflow  = r_o_ovf;
    assign o_status    = r_o_st;
endmodule

// ----- hw/rtl/amx_ctrl.sv -----
// Controller of the execute unit: clearing sweep, item sequencing and the
// result handshake. Depends on amx_pkg.
module amx_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_stall,
    output logic          o_res_valid,
    input  logic          i_res_stall,
    input  amx_pkg::t_sts i_sts,
    output amx_pkg::t_cmd o_cmd
);
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_EXE   = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_res_valid;
    logic       out_free;

    assign out_free    = !r_res_valid || !i_res_stall;
    assign o_req_stall = (r_state != S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EXE;
            end
            S_EXE: begin
                if (i_sts.is_mul) begin
                    n_state = S_MUL;
                end else if (i_sts.is_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_FIN;
            end
            S_DIV: begin
                if (i_sts.div_done) n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Advance the state, track the result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.commit) r_res_valid <= 1'b1;
            else if (!i_res_stall) r_res_valid <= 1'b0;
        end
    end

    assign o_res_valid = r_res_valid;
endmodule

// ----- hw/rtl/accumulator_machine_execute.sv -----
// Execute unit of a decimal-opcode accumulator machine.
// Items go through read, execute and finish states; multiply adds a multiply state,
// divide and remainder wait on the one-bit-per-cycle divider; one item at a time.
// Reset: synchronous active low; afterwards the data memory is cleared one word a
// cycle, all MEM_WORDS (1024) words, and no item is accepted during the sweep.
module accumulator_machine_execute (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [amx_pkg::PC_W-1:0]    i_cfg_data,
    input  logic                        i_req_valid,
    output logic                        o_req_stall,
    input  logic                        i_mode,
    input  logic [amx_pkg::OP_W-1:0]    i_opcode,
    input  logic [amx_pkg::OPND_W-1:0]  i_operand,
    input  logic signed [amx_pkg::WORD_W-1:0] i_in_value,
    output logic                        o_res_valid,
    input  logic                        i_res_stall,
    output logic [amx_pkg::PC_W-1:0]    o_next_pc,
    output logic                        o_out_valid,
    output logic signed [amx_pkg::WORD_W-1:0] o_out_value,
    output logic                        o_newline,
    output logic                        o_overflow,
    output logic [amx_pkg::ST_W-1:0]    o_status
);
    amx_pkg::t_cmd cmd;
    amx_pkg::t_sts sts;

    amx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    amx_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_mode      (i_mode),
        .i_opcode    (i_opcode),
        .i_operand   (i_operand),
        .i_in_value  (i_in_value),
        .o_next_pc   (o_next_pc),
        .o_out_valid (o_out_valid),
        .o_out_value (o_out_value),
        .o_newline   (o_newline),
        .o_overflow  (o_overflow),
        .o_status    (o_status)
    );
endmodule

// ----- hw/rtl/amx_checker.sv -----
// Port-level checks for the execute unit, bound to the top level.
// Depends on amx_pkg and accumulator_machine_execute.
module amx_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_req_stall,
    input logic                       o_res_valid,
    input logic                       i_res_stall,
    input logic [amx_pkg::PC_W-1:0]   o_next_pc,
    input logic                       o_out_valid,
    input logic                       o_newline,
    input logic [amx_pkg::ST_W-1:0]   o_status
);
    // No result beat right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_stall |=> o_res_valid && $stable(o_next_pc) && $stable(o_status))
        else $error("stalled result changed");

    // One instruction cannot both write out and emit a newline
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !(o_out_valid && o_newline))
        else $error("write and newline in one beat");

    // Status and counter stay in range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_status <= amx_pkg::ST_INVALID) && (o_next_pc <= 11'd1024))
        else $error("result field out of range");

    // Input is stalled while a result is being produced
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res_valid) |-> $past(o_req_stall))
        else $error("result produced while accepting");
endmodule

bind accumulator_machine_execute amx_checker u_amx_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_req_stall (o_req_stall),
    .o_res_valid (o_res_valid),
    .i_res_stall (i_res_stall),
    .o_next_pc   (o_next_pc),
    .o_out_valid (o_out_valid),
    .o_newline   (o_newline),
    .o_status    (o_status)
);

// ----- tb/tb.sv -----
// Testbench for accumulator_machine_execute. It drives preload and execute beats,
// predicts each result with an in-house model of the machine, and compares field by field.
// Depends on amx_pkg and the accumulator_machine_execute RTL.
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic                              mode;
        logic [amx_pkg::OP_W-1:0]          opcode;
        logic [amx_pkg::OPND_W-1:0]        operand;
        logic signed [amx_pkg::WORD_W-1:0] value;
    } t_instr;

    typedef struct packed {
        logic [amx_pkg::PC_W-1:0]          next_pc;
        logic                              out_valid;
        logic signed [amx_pkg::WORD_W-1:0] out_value;
        logic                              newline;
        logic                              overflow;
        logic [amx_pkg::ST_W-1:0]          status;
    } t_outcome;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic [amx_pkg::PC_W-1:0]          i_cfg_data;
    logic                              i_req_valid;
    logic                              o_req_stall;
    logic                              i_mode;
    logic [amx_pkg::OP_W-1:0]          i_opcode;
    logic [amx_pkg::OPND_W-1:0]        i_operand;
    logic signed [amx_pkg::WORD_W-1:0] i_in_value;
    logic                              o_res_valid;
    logic                              i_res_stall;
    logic [amx_pkg::PC_W-1:0]          o_next_pc;
    logic                              o_out_valid;
    logic signed [amx_pkg::WORD_W-1:0] o_out_value;
    logic                              o_newline;
    logic                              o_overflow;
    logic [amx_pkg::ST_W-1:0]          o_status;

    accumulator_machine_execute u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_mode      (i_mode),
        .i_opcode    (i_opcode),
        .i_operand   (i_operand),
        .i_in_value  (i_in_value),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .o_next_pc   (o_next_pc),
        .o_out_valid (o_out_valid),
        .o_out_value (o_out_value),
        .o_newline   (o_newline),
        .o_overflow  (o_overflow),
        .o_status    (o_status)
    );

    // Machine shadow state
    logic [amx_pkg::WORD_W-1:0] data_mem [amx_pkg::MEM_WORDS];
    logic [amx_pkg::PC_W-1:0]   prog_ctr;
    logic [amx_pkg::ST_W-1:0]   run_st;
    logic [amx_pkg::PC_W-1:0]   prog_len;

    t_instr   pending_q[$];
    t_outcome expected_q[$];
    int       mismatches;
    int       send_idle_pct;
    int       recv_idle_pct;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Time limit
    initial begin
        #40ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [amx_pkg::WORD_W-1:0] clamp_word(input longint v,
                                                               inout logic ovf);
        if (v > 64'sd2147483647) begin
            ovf = 1'b1;
            return amx_pkg::WORD_MAX;
        end
        if (v < -64'sd2147483648) begin
            ovf = 1'b1;
            return amx_pkg::WORD_MIN;
        end
        return v[amx_pkg::WORD_W-1:0];
    endfunction

    // Advance the shadow machine by one beat and return its result
    function automatic t_outcome machine_step(input t_instr it);
        t_outcome r;
        longint   acc;
        longint   m;
        logic     ovf;
        r   = '0;
        ovf = 1'b0;
        if (!it.mode) begin
            data_mem[it.operand] = it.value;
        end else if (run_st == amx_pkg::ST_RUN) begin
            if (prog_ctr >= prog_len) begin
                run_st = amx_pkg::ST_END;
            end else begin
                acc = longint'($signed(data_mem[amx_pkg::ACC_INDEX]));
                m   = longint'($signed(data_mem[it.operand]));
                prog_ctr = prog_ctr + 1'b1;
                case (it.opcode)
                    amx_pkg::OP_READ:    data_mem[it.operand] = it.value;
                    amx_pkg::OP_WRITE: begin
                        r.out_valid = 1'b1;
                        r.out_value = data_mem[it.operand];
                    end
                    amx_pkg::OP_NEWLINE: r.newline = 1'b1;
                    amx_pkg::OP_LOAD:
                        data_mem[amx_pkg::ACC_INDEX] = data_mem[it.operand];
                    amx_pkg::OP_STORE:
                        data_mem[it.operand] = data_mem[amx_pkg::ACC_INDEX];
                    amx_pkg::OP_ADD:
                        data_mem[amx_pkg::ACC_INDEX] = clamp_word(acc + m, ovf);
                    amx_pkg::OP_SUB:
                        data_mem[amx_pkg::ACC_INDEX] = clamp_word(acc - m, ovf);
                    amx_pkg::OP_MUL:
                        data_mem[amx_pkg::ACC_INDEX] = clamp_word(acc * m, ovf);
                    amx_pkg::OP_DIV: begin
                        if (m == 0) run_st = amx_pkg::ST_DIVZERO;
                        else data_mem[amx_pkg::ACC_INDEX] = clamp_word(acc / m, ovf);
                    end
                    amx_pkg::OP_REM: begin
                        if (m == 0) run_st = amx_pkg::ST_DIVZERO;
                        else data_mem[amx_pkg::ACC_INDEX] = clamp_word(acc % m, ovf);
                    end
                    amx_pkg::OP_JMP:     prog_ctr = amx_pkg::PC_W'(it.operand);
                    amx_pkg::OP_JNEG:    if (acc < 0) prog_ctr = amx_pkg::PC_W'(it.operand);
                    amx_pkg::OP_JZERO:   if (acc == 0) prog_ctr = amx_pkg::PC_W'(it.operand);
                    amx_pkg::OP_STOP:    run_st = amx_pkg::ST_STOP;
                    default:             run_st = amx_pkg::ST_INVALID;
                endcase
                if (run_st == amx_pkg::ST_RUN && prog_ctr >= prog_len)
                    run_st = amx_pkg::ST_END;
            end
        end
        r.next_pc  = prog_ctr;
        r.overflow = ovf;
        r.status   = run_st;
        return r;
    endfunction

    // Queue a beat together with its predicted result
    task automatic issue(input logic mode, input logic [amx_pkg::OP_W-1:0] op,
                         input int addr, input logic [amx_pkg::WORD_W-1:0] val);
        t_instr it;
        it.mode    = mode;
        it.opcode  = op;
        it.operand = amx_pkg::OPND_W'(addr);
        it.value   = val;
        pending_q.push_back(it);
        expected_q.push_back(machine_step(it));
    endtask

    task automatic drain();
        while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_length(input int len);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= amx_pkg::PC_W'(len);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        prog_len = amx_pkg::PC_W'(len);
    endtask

    function automatic int pick_addr();
        if ($urandom_range(0, 99) < 70) return $urandom_range(0, 15);
        return $urandom_range(0, amx_pkg::MEM_WORDS - 1);
    endfunction

    function automatic logic [amx_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return amx_pkg::WORD_MAX;
            1: return amx_pkg::WORD_MIN;
            2: return 32'hFFFF_FFFF;
            3: return 32'd0;
            4: return amx_pkg::WORD_W'($urandom_range(0, 20)) - 32'd10;
            5: return amx_pkg::WORD_W'($urandom_range(0, 200000)) - 32'd100000;
            default: return $urandom;
        endcase
    endfunction

    // One random beat that keeps the machine running
    task automatic random_beat();
        logic [amx_pkg::OP_W-1:0] ops [13];
        logic [amx_pkg::OP_W-1:0] op;
        int                       addr;
        ops = '{amx_pkg::OP_READ, amx_pkg::OP_WRITE, amx_pkg::OP_NEWLINE,
                amx_pkg::OP_LOAD, amx_pkg::OP_STORE, amx_pkg::OP_ADD, amx_pkg::OP_SUB,
                amx_pkg::OP_MUL, amx_pkg::OP_DIV, amx_pkg::OP_REM, amx_pkg::OP_JMP,
                amx_pkg::OP_JNEG, amx_pkg::OP_JZERO};
        if ($urandom_range(0, 99) < 25) begin
            issue(1'b0, amx_pkg::OP_W'($urandom_range(0, 99)), pick_addr(), pick_word());
        end else if (int'(prog_ctr) >= int'(prog_len) - 1) begin
            issue(1'b1, amx_pkg::OP_JMP, $urandom_range(0, int'(prog_len) - 2), $urandom);
        end else begin
            op   = ops[$urandom_range(0, 12)];
            addr = pick_addr();
            if (op == amx_pkg::OP_JMP || op == amx_pkg::OP_JNEG || op == amx_pkg::OP_JZERO)
                addr = $urandom_range(0, int'(prog_len) - 2);
            if ((op == amx_pkg::OP_DIV || op == amx_pkg::OP_REM) && data_mem[addr] == '0)
                op = amx_pkg::OP_ADD;
            issue(1'b1, op, addr, pick_word());
        end
    endtask

    // Beat driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
        end else if (!i_req_valid || !o_req_stall) begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_req_valid <= 1'b1;
                i_mode      <= pending_q[0].mode;
                i_opcode    <= pending_q[0].opcode;
                i_operand   <= pending_q[0].operand;
                i_in_value  <= pending_q[0].value;
                void'(pending_q.pop_front());
            end else begin
                i_req_valid <= 1'b0;
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        t_outcome got;
        t_outcome want;
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            got = '{o_next_pc, o_out_valid, o_out_value, o_newline, o_overflow, o_status};
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", got);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("mismatch: pc %0d/%0d ov %b/%b val %0d/%0d",
                               want.next_pc, got.next_pc, want.out_valid, got.out_valid,
                               want.out_value, got.out_value);
                        $display(" nl %b/%b ovf %b/%b st %0d/%0d",
                                 want.newline, got.newline, want.overflow, got.overflow,
                                 want.status, got.status);
                    end
                end
            end
        end
        i_res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Stimulus sequence
    initial begin
        int kind;
        int n;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_data = '0; i_req_valid = 1'b0;
        i_mode = 1'b0; i_opcode = '0; i_operand = '0; i_in_value = '0; i_res_stall = 1'b0;
        mismatches = 0; send_idle_pct = 0; recv_idle_pct = 0;
        foreach (data_mem[k]) data_mem[k] = '0;
        prog_ctr = '0; run_st = amx_pkg::ST_RUN; prog_len = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero-length program: preloads only
        set_length(0);
        issue(1'b0, 7'd99, 1023, amx_pkg::WORD_MAX);
        issue(1'b0, 7'd0, 0, amx_pkg::WORD_MIN);
        drain();

        // Directed: saturation, most negative over minus one, signed remainder, jumps
        set_length(amx_pkg::MEM_WORDS);
        issue(1'b0, 7'd64, amx_pkg::ACC_INDEX, amx_pkg::WORD_MAX);
        issue(1'b0, 7'd0, 1, 32'd1);
        issue(1'b1, amx_pkg::OP_ADD, 1, '0);
        issue(1'b1, amx_pkg::OP_WRITE, amx_pkg::ACC_INDEX, '0);
        issue(1'b1, amx_pkg::OP_LOAD, 0, '0);
        issue(1'b1, amx_pkg::OP_SUB, 1, '0);
        issue(1'b1, amx_pkg::OP_READ, 2, 32'hFFFF_FFFF);
        issue(1'b1, amx_pkg::OP_DIV, 2, '0);
        issue(1'b1, amx_pkg::OP_LOAD, 0, '0);
        issue(1'b1, amx_pkg::OP_REM, 2, '0);
        issue(1'b1, amx_pkg::OP_LOAD, 1023, '0);
        issue(1'b1, amx_pkg::OP_MUL, 1023, '0);
        issue(1'b1, amx_pkg::OP_READ, 3, -32'sd7);
        issue(1'b1, amx_pkg::OP_LOAD, 3, '0);
        issue(1'b1, amx_pkg::OP_READ, 4, 32'sd3);
        issue(1'b1, amx_pkg::OP_REM, 4, '0);
        issue(1'b1, amx_pkg::OP_STORE, 5, '0);
        issue(1'b1, amx_pkg::OP_NEWLINE, 0, '0);
        issue(1'b1, amx_pkg::OP_JNEG, 500, '0);
        issue(1'b1, amx_pkg::OP_JZERO, 7, '0);
        issue(1'b1, amx_pkg::OP_WRITE, 1023, '0);
        issue(1'b1, amx_pkg::OP_JMP, 1022, '0);
        issue(1'b1, amx_pkg::OP_JMP, 0, '0);
        drain();

        // Random phases with varied idling and program length
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 79 : 0;
            recv_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 24 : 0;
            issue(1'b1, amx_pkg::OP_JMP, 0, '0);
            drain();
            set_length((ph == 1) ? $urandom_range(2, 60) : amx_pkg::MEM_WORDS);
            for (int k = 0; k < 440; k++) random_beat();
            drain();
        end

        // Halt the machine one way, then check that execution stays frozen
        issue(1'b1, amx_pkg::OP_JMP, 0, '0);
        drain();
        kind = $urandom_range(0, 4);
        case (kind)
            0: issue(1'b1, amx_pkg::OP_STOP, pick_addr(), $urandom);
            1: issue(1'b1, amx_pkg::OP_W'($urandom_range(64, 99)), pick_addr(), $urandom);
            2: begin
                issue(1'b0, 7'd0, 6, '0);
                issue(1'b1, ($urandom_range(0, 1) != 0) ? amx_pkg::OP_DIV : amx_pkg::OP_REM,
                      6, '0);
            end
            3: begin
                set_length(600);
                issue(1'b1, amx_pkg::OP_JMP, 700, '0);
            end
            default: begin
                set_length(0);
                issue(1'b1, amx_pkg::OP_WRITE, 0, '0);
            end
        endcase
        n = 0;
        while (n < 20) begin
            issue(1'(($urandom_range(0, 2) != 0)), amx_pkg::OP_W'($urandom_range(0, 99)),
                  pick_addr(), pick_word());
            n++;
        end
        drain();

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
